// ===== rtl/knnmv_pkg.sv =====
// ----------------------------------------------------------------------------
// knnmv_pkg
// Shared widths for the k-nearest-neighbor majority vote unit.
// ----------------------------------------------------------------------------
`default_nettype none

package knnmv_pkg;

	localparam int LABEL_W = 8;   // class label width
	localparam int VOTES_W = 7;   // per-class vote count width
	localparam int CNT_MAX = 127; // largest count the counter can hold

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [VOTES_W-1:0] votes_t;

endpackage : knnmv_pkg

`default_nettype wire

// ===== rtl/knn_majority_vote_unit.sv =====
// ----------------------------------------------------------------------------
// knn_majority_vote_unit
// Plurality vote over a group of class labels, smallest label wins a tie.
//
// Input channel (vote_valid / vote_stall): one item per neighbor, holding its
// class label and a last flag that closes the group. An item is taken on
// every cycle, back to back, as long as the result side keeps up.
// Output channel (result_valid / result_stall): one item per group, holding
// the winning label and its vote count, registered once the last label of
// the group has left the count stage.
// Throughput: one label per cycle while the result side keeps up. The
// per-class counts sit in one memory with a synchronous read; each label
// is a read-modify-write; a label that follows the same class on the next
// cycle takes its count from a forwarding register instead of the memory.
// Counts are cleared between groups through one valid bit per class, all
// dropped in the cycle the vote is taken, so no clearing pass is needed.
// Reset clears the valid bits, the running best and the handshake state.
// When the receiver stalls while a result is held, a last label waiting in
// the count stage holds, and the input stall rises for that time.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_majority_vote_unit
	import knnmv_pkg::*;
#(
	parameter int NUM_CLASSES = 256,
	parameter int MAX_VOTERS  = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   vote_valid,
	output logic        vote_stall,
	input  wire label_t label,
	input  wire logic   last,
	output logic        result_valid,
	input  wire logic   result_stall,
	output label_t      winner,
	output votes_t      votes
);

	// labels are 8 bits wide, so at most 256 classes can ever be addressed
	localparam int DEPTH    = (NUM_CLASSES < 256) ? NUM_CLASSES : 256;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VOTE_CAP = (MAX_VOTERS < CNT_MAX) ? MAX_VOTERS : CNT_MAX;

	// count memory and its per-class valid bits
	votes_t            cnt_mem [DEPTH];
	votes_t            rd_data_s1;
	logic [DEPTH-1:0]  seen_q;

	// count stage
	logic              valid_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              fwd_s1;
	votes_t            fwd_cnt_s1;

	// running best
	label_t            best_label_q;
	votes_t            best_count_q;

	// result register
	logic              out_valid_q;
	label_t            winner_q;
	votes_t            votes_q;

	logic              accept;
	logic              advance;
	logic              fire_s1;
	label_t            label_clamped;
	logic [IDX_W-1:0]  idx_in;
	votes_t            old_cnt;
	votes_t            new_cnt;
	label_t            idx_ext;
	logic              take_best;
	label_t            next_label;
	votes_t            next_count;

	// out-of-range labels fall into the top class
	always_comb begin
		if ({9'd0, label} >= 17'(NUM_CLASSES)) begin
			label_clamped = LABEL_W'(NUM_CLASSES - 1);
		end else begin
			label_clamped = label;
		end
		idx_in = label_clamped[IDX_W-1:0];
	end

	// a last label may only leave the count stage if the result slot frees up
	assign advance    = !(last_s1 && out_valid_q && result_stall);
	assign fire_s1    = valid_s1 && advance;
	assign vote_stall = valid_s1 && !advance;
	assign accept     = vote_valid && !vote_stall;

	// count update: forwarded value, stored value, or zero for a fresh class, plus one up to the vote cap
	always_comb begin
		if (fwd_s1) begin
			old_cnt = fwd_cnt_s1;
		end else if (seen_q[idx_s1]) begin
			old_cnt = rd_data_s1;
		end else begin
			old_cnt = '0;
		end
		if (old_cnt < VOTES_W'(VOTE_CAP)) begin
			new_cnt = old_cnt + VOTES_W'(1);
		end else begin
			new_cnt = old_cnt;
		end
	end

	// running best: higher count wins, equal count goes to the smaller label
	always_comb begin
		idx_ext   = LABEL_W'(idx_s1);
		take_best = (new_cnt > best_count_q) ||
			((new_cnt == best_count_q) && (idx_ext < best_label_q));
		if (take_best) begin
			next_label = idx_ext;
			next_count = new_cnt;
		end else begin
			next_label = best_label_q;
			next_count = best_count_q;
		end
	end

	// memory port: read on accept, write back from the count stage
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= cnt_mem[idx_in];
		end
		if (fire_s1) begin
			cnt_mem[idx_s1] <= new_cnt;
		end
	end

	// stage payload, plus forwarding when the same class follows directly
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= idx_in;
			last_s1    <= last;
			fwd_s1     <= fire_s1 && !last_s1 && (idx_s1 == idx_in);
			fwd_cnt_s1 <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// valid bits and running best, all dropped when a group closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			best_label_q <= '0;
			best_count_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				seen_q       <= '0;
				best_label_q <= '0;
				best_count_q <= '0;
			end else begin
				seen_q[idx_s1] <= 1'b1;
				best_label_q   <= next_label;
				best_count_q   <= next_count;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			winner_q <= next_label;
			votes_q  <= next_count;
		end
	end

	assign result_valid = out_valid_q;
	assign winner       = winner_q;
	assign votes        = votes_q;

endmodule : knn_majority_vote_unit

`default_nettype wire
